// ----- design/psq_pkg.sv -----
package psq_pkg;

	// Fixed field widths of the command and result words
	localparam int POS_W       = 8;
	localparam int VAL_W       = 32;
	localparam int CNT_OUT_W   = 5;

	// Defaults for the top level parameters
	localparam int CAPACITY_DEF   = 16;
	localparam int ITEM_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_WRITE  = 2'd3
	} op_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic             ins;
		logic             del;
		logic             wr;
		logic [POS_W-1:0] pos_m1;
	} cmd_t;

endpackage

// ----- design/psq_dec.sv -----
module psq_dec #(
	parameter int CAPACITY = 16
) (
	input  logic                        accept,
	input  logic [1:0]                  operation,
	input  logic [psq_pkg::POS_W-1:0]   position,
	input  logic [$clog2(CAPACITY+1)-1:0] count,
	output psq_pkg::cmd_t               cmd,
	output logic                        ok,
	output logic                        rd_en,
	output logic [$clog2(CAPACITY+1)-1:0] count_nxt
);
	import psq_pkg::*;

	localparam int CW   = $clog2(CAPACITY+1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [CMPW-1:0] pos_e;
	logic [CMPW-1:0] cnt_e;
	logic            pos_nz;
	logic            ins_ok;
	logic            acc_ok;
	op_t             op;

	// Range checks on a common width
	assign pos_e  = CMPW'(position);
	assign cnt_e  = CMPW'(count);
	assign pos_nz = (position != '0);
	assign ins_ok = pos_nz && (pos_e <= cnt_e + CMPW'(1)) && (cnt_e < CMPW'(CAPACITY));
	assign acc_ok = pos_nz && (pos_e <= cnt_e);
	assign op     = op_t'(operation);

	// Operation decode
	always_comb begin
		cmd.ins    = 1'b0;
		cmd.del    = 1'b0;
		cmd.wr     = 1'b0;
		cmd.pos_m1 = position - POS_W'(1);
		ok         = 1'b0;
		rd_en      = 1'b0;
		count_nxt  = count;
		unique case (op)
			OP_INSERT: begin
				ok      = ins_ok;
				cmd.ins = accept && ins_ok;
				if (accept && ins_ok) begin
					count_nxt = count + CW'(1);
				end
			end
			OP_DELETE: begin
				ok      = acc_ok;
				cmd.del = accept && acc_ok;
				if (accept && acc_ok) begin
					count_nxt = count - CW'(1);
				end
			end
			OP_READ: begin
				ok    = acc_ok;
				rd_en = acc_ok;
			end
			OP_WRITE: begin
				ok     = acc_ok;
				cmd.wr = accept && acc_ok;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

endmodule

// ----- design/psq_cell.sv -----
module psq_cell #(
	parameter int CAPACITY   = 16,
	parameter int ITEM_WIDTH = 32,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  psq_pkg::cmd_t         cmd,
	input  logic [ITEM_WIDTH-1:0] din,
	input  logic [ITEM_WIDTH-1:0] left_data,
	input  logic [ITEM_WIDTH-1:0] right_data,
	output logic [ITEM_WIDTH-1:0] data,
	output logic [ITEM_WIDTH-1:0] rd_word
);
	import psq_pkg::*;

	localparam int AW  = $clog2(CAPACITY);
	localparam int IW  = ((AW > POS_W) ? AW : POS_W) + 1;

	logic [ITEM_WIDTH-1:0] data_q;
	logic [ITEM_WIDTH-1:0] data_nxt;
	logic                  hit;
	logic                  above;

	// Where this cell sits relative to the addressed position
	assign hit   = (IW'(IDX) == IW'(cmd.pos_m1));
	assign above = (IW'(IDX) >  IW'(cmd.pos_m1));

	// Insert shifts up from the left, delete shifts down from the right
	always_comb begin
		data_nxt = data_q;
		if (cmd.ins && hit) begin
			data_nxt = din;
		end else if (cmd.ins && above) begin
			data_nxt = left_data;
		end else if (cmd.del && (hit || above)) begin
			data_nxt = right_data;
		end else if (cmd.wr && hit) begin
			data_nxt = din;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data    = data_q;
	assign rd_word = hit ? data_q : '0;

endmodule

// ----- design/positional_sequence_store.sv -----
// Channel  | Strobe     | Fields
// ---------+------------+---------------------------------------------
// command  | start/busy | operation, position, item_value
// result   | done       | ok, read_value, entry_count, empty
//
// One word per clock: a command taken at an edge updates every cell at that
// same edge, and its result shows in the next cycle with done high.
// busy never rises; the cell row shifts all entries at once.
// Reset clears the count; entry contents are undefined until written.
// The receiver cannot stall: each result is valid for exactly one cycle.
module positional_sequence_store #(
	parameter int CAPACITY   = psq_pkg::CAPACITY_DEF,
	parameter int ITEM_WIDTH = psq_pkg::ITEM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    operation,
	input  logic [psq_pkg::POS_W-1:0]     position,
	input  logic [psq_pkg::VAL_W-1:0]     item_value,
	output logic                          done,
	output logic                          ok,
	output logic [psq_pkg::VAL_W-1:0]     read_value,
	output logic [psq_pkg::CNT_OUT_W-1:0] entry_count,
	output logic                          empty
);
	import psq_pkg::*;

	localparam int CW = $clog2(CAPACITY+1);

	logic                  accept;
	cmd_t                  cmd;
	logic                  dec_ok;
	logic                  rd_en;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_nxt;
	logic [ITEM_WIDTH-1:0] din;
	logic [ITEM_WIDTH-1:0] cell_data [CAPACITY];
	logic [ITEM_WIDTH-1:0] cell_rd   [CAPACITY];
	logic [ITEM_WIDTH-1:0] rd_or;
	logic [VAL_W-1:0]      rd_val;
	logic                  done_q;
	logic                  ok_q;
	logic [VAL_W-1:0]      read_value_q;
	logic [CW-1:0]         res_count_q;
	logic [CW+CNT_OUT_W-1:0] count_ext;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	psq_dec #(
		.CAPACITY (CAPACITY)
	) u_dec (
		.accept    (accept),
		.operation (operation),
		.position  (position),
		.count     (count_q),
		.cmd       (cmd),
		.ok        (dec_ok),
		.rd_en     (rd_en),
		.count_nxt (count_nxt)
	);

	// Incoming word trimmed or padded to the entry width
	for (genvar b = 0; b < ITEM_WIDTH; b++) begin : g_din
		if (b < VAL_W) begin : g_in
			assign din[b] = item_value[b];
		end else begin : g_pad
			assign din[b] = 1'b0;
		end
	end

	// Row of entry cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [ITEM_WIDTH-1:0] left_w;
		logic [ITEM_WIDTH-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end
		if (g == CAPACITY-1) begin : g_last
			assign right_w = cell_data[g];
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end
		psq_cell #(
			.CAPACITY   (CAPACITY),
			.ITEM_WIDTH (ITEM_WIDTH),
			.IDX        (g)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.din        (din),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[g]),
			.rd_word    (cell_rd[g])
		);
	end

	// Only the addressed cell drives a nonzero read word
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	for (genvar b = 0; b < VAL_W; b++) begin : g_rd
		if (b < ITEM_WIDTH) begin : g_bit
			assign rd_val[b] = rd_en && rd_or[b];
		end else begin : g_zero
			assign rd_val[b] = 1'b0;
		end
	end

	// Held count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q         <= dec_ok;
			read_value_q <= rd_val;
			res_count_q  <= count_nxt;
		end
	end

	assign count_ext   = (CW+CNT_OUT_W)'(res_count_q);
	assign done        = done_q;
	assign ok          = ok_q;
	assign read_value  = read_value_q;
	assign entry_count = count_ext[CNT_OUT_W-1:0];
	assign empty       = (res_count_q == '0);

endmodule

// ----- design/psq_chk.sv -----
module psq_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [1:0]                    operation,
	input logic [psq_pkg::POS_W-1:0]     position,
	input logic [psq_pkg::VAL_W-1:0]     item_value,
	input logic                          done,
	input logic                          ok,
	input logic [psq_pkg::VAL_W-1:0]     read_value,
	input logic [psq_pkg::CNT_OUT_W-1:0] entry_count,
	input logic                          empty
);
	import psq_pkg::*;

	// Every accepted word gives exactly one result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted word gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without an accepted word");

	// Position zero is never valid
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && position == '0) |=> (done && !ok))
		else $error("position zero was performed");

	// A refused operation reads as zero
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (read_value == '0))
		else $error("refused result carries data");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && empty) |-> (entry_count == '0))
		else $error("empty flag with nonzero count");

endmodule

bind positional_sequence_store psq_chk u_psq_chk (.*);

// ----- tb/tb.sv -----
module tb;
	import psq_pkg::*;

	localparam int CAPACITY   = 16;
	localparam int CYCLE_CAP  = 200000;
	localparam int DRAIN_WAIT = 4;

	// one expected result word
	typedef struct packed {
		logic                 ok;
		logic [VAL_W-1:0]     read_value;
		logic [CNT_OUT_W-1:0] entry_count;
		logic                 empty;
	} seq_result_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic                 busy;
	logic [1:0]           operation  = OP_READ;
	logic [POS_W-1:0]     position   = '0;
	logic [VAL_W-1:0]     item_value = '0;
	logic                 done;
	logic                 ok;
	logic [VAL_W-1:0]     read_value;
	logic [CNT_OUT_W-1:0] entry_count;
	logic                 empty;

	// shadow of the sequence contents and the entry count
	logic [VAL_W-1:0] shadow_words [CAPACITY];
	int               held = 0;

	seq_result_t awaited_results [$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          idle_pct       = 0;

	positional_sequence_store #(
		.CAPACITY   (CAPACITY),
		.ITEM_WIDTH (VAL_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.position    (position),
		.item_value  (item_value),
		.done        (done),
		.ok          (ok),
		.read_value  (read_value),
		.entry_count (entry_count),
		.empty       (empty)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// apply one command to the shadow sequence and return its result
	function automatic seq_result_t seq_apply(op_t op, logic [POS_W-1:0] pos,
			logic [VAL_W-1:0] val);
		seq_result_t r;
		int          p;
		r = '0;
		p = pos;
		case (op)
			OP_INSERT: begin
				if (p >= 1 && p <= held + 1 && held < CAPACITY) begin
					for (int i = held; i > p - 1; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[p-1] = val;
					held++;
					r.ok = 1'b1;
				end
			end
			OP_DELETE: begin
				if (p >= 1 && p <= held) begin
					for (int i = p - 1; i + 1 < held; i++)
						shadow_words[i] = shadow_words[i+1];
					held--;
					r.ok = 1'b1;
				end
			end
			OP_READ: begin
				if (p >= 1 && p <= held) begin
					r.read_value = shadow_words[p-1];
					r.ok = 1'b1;
				end
			end
			default: begin
				if (p >= 1 && p <= held) begin
					shadow_words[p-1] = val;
					r.ok = 1'b1;
				end
			end
		endcase
		r.entry_count = held[CNT_OUT_W-1:0];
		r.empty       = (held == 0);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// drive one command word, wait until it is taken, then predict it
	task automatic send_word(op_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
		start      <= 1'b1;
		operation  <= op;
		position   <= pos;
		item_value <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		awaited_results.push_back(seq_apply(op, pos, val));
		// optional gap with junk on the fields
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start      <= 1'b0;
			operation  <= 2'($urandom_range(3));
			position   <= POS_W'($urandom_range(255));
			item_value <= $urandom;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	// result checker: done is a one-cycle strobe
	always @(posedge clk) begin
		seq_result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want = awaited_results.pop_front();
				if (ok !== want.ok)
					report_mismatch($sformatf("ok %b, expected %b", ok, want.ok));
				if (read_value !== want.read_value)
					report_mismatch($sformatf("read_value %h, expected %h",
						read_value, want.read_value));
				if (entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count %0d, expected %0d",
						entry_count, want.entry_count));
				if (empty !== want.empty)
					report_mismatch($sformatf("empty %b, expected %b",
						empty, want.empty));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// empty store, bounds, prepend / append / middle edits, delete to empty
	task automatic test_edit_ops();
		send_word(OP_READ,   8'd1,   32'h1234_5678);
		send_word(OP_DELETE, 8'd1,   32'h0);
		send_word(OP_WRITE,  8'd1,   32'hDEAD_BEEF);
		send_word(OP_INSERT, 8'd0,   32'h1111_1111);
		send_word(OP_INSERT, 8'd2,   32'h2222_2222);
		send_word(OP_INSERT, 8'd1,   32'hFFFF_FFFF);
		send_word(OP_INSERT, 8'd2,   32'h0000_0000);
		send_word(OP_INSERT, 8'd1,   32'hA5A5_A5A5);
		send_word(OP_INSERT, 8'd2,   32'h5A5A_5A5A);
		for (int i = 1; i <= 4; i++)
			send_word(OP_READ, i[POS_W-1:0], 32'h0);
		send_word(OP_READ,   8'd5,   32'h0);
		send_word(OP_READ,   8'd255, 32'hFFFF_FFFF);
		send_word(OP_WRITE,  8'd4,   32'h8000_0001);
		send_word(OP_WRITE,  8'd5,   32'h7FFF_FFFE);
		send_word(OP_DELETE, 8'd5,   32'h0);
		send_word(OP_DELETE, 8'd0,   32'h0);
		send_word(OP_READ,   8'd4,   32'h0);
		send_word(OP_DELETE, 8'd2,   32'h0);
		send_word(OP_DELETE, 8'd3,   32'h0);
		send_word(OP_DELETE, 8'd1,   32'h0);
		send_word(OP_DELETE, 8'd1,   32'h0);
		send_word(OP_INSERT, 8'd255, 32'hFFFF_FFFF);
	endtask

	// fill to capacity, refuse inserts when full, then drain from the back
	task automatic test_full_store();
		while (held < CAPACITY)
			send_word(OP_INSERT, POS_W'($urandom_range(held + 1, 1)), $urandom);
		send_word(OP_INSERT, 8'd1,   $urandom);
		send_word(OP_INSERT, POS_W'(CAPACITY + 1), $urandom);
		send_word(OP_READ,   POS_W'(CAPACITY), 32'h0);
		send_word(OP_READ,   POS_W'(CAPACITY + 1), 32'h0);
		send_word(OP_WRITE,  POS_W'(CAPACITY), 32'hFFFF_FFFF);
		send_word(OP_READ,   POS_W'(CAPACITY), 32'h0);
		while (held > 0)
			send_word(OP_DELETE, held[POS_W-1:0], 32'h0);
	endtask

	// mostly in-range commands that sweep the store between empty and full
	task automatic test_random_traffic(int n_words, int pct, bit mixed);
		bit          grow;
		int          roll;
		op_t         op;
		int          pos;
		logic [31:0] val;
		grow = 1'b1;
		idle_pct = pct;
		for (int k = 0; k < n_words; k++) begin
			if (mixed && k % 50 == 0)
				idle_pct = (idle_pct == 0) ? 58 : 0;
			if (held == CAPACITY && $urandom_range(3) == 0)
				grow = 1'b0;
			if (held == 0)
				grow = 1'b1;
			roll = $urandom_range(99);
			case ($urandom_range(7))
				0:       val = 32'h0;
				1:       val = 32'hFFFF_FFFF;
				default: val = $urandom;
			endcase
			if (roll < 10) begin
				// noise: anything the fields allow
				op  = op_t'($urandom_range(3));
				pos = $urandom_range(255);
			end else if (roll < 16) begin
				// just outside the valid range
				op  = op_t'($urandom_range(3));
				pos = (op == OP_INSERT) ? held + 2 : (roll[0] ? 0 : held + 1);
			end else begin
				roll = $urandom_range(99);
				if (grow)
					op = (roll < 55) ? OP_INSERT : (roll < 70) ? OP_DELETE :
						(roll < 88) ? OP_READ : OP_WRITE;
				else
					op = (roll < 55) ? OP_DELETE : (roll < 70) ? OP_INSERT :
						(roll < 88) ? OP_READ : OP_WRITE;
				if (op == OP_INSERT)
					pos = $urandom_range(held + 1, 1);
				else
					pos = (held == 0) ? 1 : $urandom_range(held, 1);
			end
			send_word(op, pos[POS_W-1:0], val);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 0;
		test_edit_ops();
		test_full_store();
		test_random_traffic(400, 0, 1'b0);
		test_random_traffic(400, 58, 1'b0);
		test_random_traffic(400, 25, 1'b0);
		test_random_traffic(400, 0, 1'b1);
		idle_pct = 30;
		test_full_store();

		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
